// ===== rtl/wsbt_pkg.sv =====
package wsbt_pkg;

  localparam int ADC_BITS   = 12;
  localparam int MAX_WINDOW = 30;

  // register field widths and reset values
  localparam int TOL_W = 8;
  localparam int WIN_W = 5;
  localparam logic [TOL_W-1:0] TOL_RESET = 8'd10;
  localparam logic [WIN_W-1:0] WIN_RESET = 5'd20;

  // configuration port
  localparam int DATA_W = 32;
  localparam int ADDR_W = 4;
  localparam int IDX_W  = 2;

  typedef enum logic [IDX_W-1:0] {
    REG_ENABLE    = 2'd0,
    REG_TOLERANCE = 2'd1,
    REG_WINDOW    = 2'd2
  } reg_idx_t;

endpackage

// ===== rtl/wsbt_if.sv =====
interface wsbt_sample_if #(
  parameter int ADC_BITS = wsbt_pkg::ADC_BITS
);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] right_raw;
  logic [ADC_BITS-1:0] left_raw;

  modport source (output valid, output right_raw, output left_raw, input ready);
  modport sink (input valid, input right_raw, input left_raw, output ready);
endinterface

interface wsbt_result_if #(
  parameter int ADC_BITS = wsbt_pkg::ADC_BITS
);
  logic                       valid;
  logic                       ready;
  logic signed [ADC_BITS:0]   right_base;
  logic signed [ADC_BITS:0]   left_base;
  logic signed [ADC_BITS+1:0] right_offset;
  logic signed [ADC_BITS+1:0] left_offset;
  logic                       right_rebased;
  logic                       left_rebased;

  modport source (
    output valid, output right_base, output left_base, output right_offset,
    output left_offset, output right_rebased, output left_rebased, input ready
  );
  modport sink (
    input valid, input right_base, input left_base, input right_offset,
    input left_offset, input right_rebased, input left_rebased, output ready
  );
endinterface

// ===== rtl/wall_sensor_baseline_tracker_top.sv =====
// channel   dir   handshake       payload
// sample    in    valid/ready     right_raw, left_raw
// result    out   valid/ready     right/left_base, right/left_offset, right/left_rebased
// apb       in    psel/penable    paddr, pwdata, pwrite -> prdata (pready tied high)
//
// one item at a time: an enabled tick runs both channels, right then left, through
// one shared restoring divider, each channel passing SETUP, LOAD, ITER, AVG and
// DECIDE; a disabled tick goes straight to DONE. sample.ready is high only while idle.
// a finished item waits in its own state until the result register is free.
// rst is synchronous: baselines, sums, counts clear, registers take defaults.
module wall_sensor_baseline_tracker_top #(
  parameter int ADC_BITS   = wsbt_pkg::ADC_BITS,
  parameter int MAX_WINDOW = wsbt_pkg::MAX_WINDOW
) (
  input  logic                        clk,
  input  logic                        rst,
  wsbt_sample_if.sink                 sample,
  wsbt_result_if.source               result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wsbt_pkg::ADDR_W-1:0] paddr,
  input  logic [wsbt_pkg::DATA_W-1:0] pwdata,
  output logic [wsbt_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int BASE_W  = ADC_BITS + 1;
  localparam int OFF_W   = ADC_BITS + 2;
  localparam int EXT_W   = ADC_BITS + 3;
  localparam int COUNT_W = $clog2(MAX_WINDOW + 2);
  localparam int SUM_W   = OFF_W + COUNT_W;
  localparam int Q_W     = OFF_W;
  localparam int IT_W    = $clog2(Q_W);
  localparam int CMP_W   = (COUNT_W > wsbt_pkg::WIN_W) ? COUNT_W : wsbt_pkg::WIN_W;
  localparam logic signed [EXT_W-1:0] BASE_MAX = EXT_W'((1 << ADC_BITS) - 1);
  localparam logic signed [EXT_W-1:0] BASE_MIN = EXT_W'(-(1 << ADC_BITS));

  typedef enum logic [2:0] {
    IDLE, SETUP, LOAD, ITER, AVG, DECIDE, DONE
  } state_t;

  state_t state;
  logic   ch;

  logic                       dyn_en;
  logic [wsbt_pkg::TOL_W-1:0] tolerance;
  logic [wsbt_pkg::WIN_W-1:0] window;

  logic signed [SUM_W-1:0]  sum      [2];
  logic [COUNT_W-1:0]       count    [2];
  logic signed [BASE_W-1:0] baseline [2];
  logic signed [OFF_W-1:0]  off      [2];
  logic                     reb      [2];

  logic signed [SUM_W-1:0] wsum;
  logic [COUNT_W-1:0]      wcnt;
  logic                    neg;
  logic [COUNT_W-1:0]      rem;
  logic [Q_W-1:0]          dvd;
  logic [IT_W-1:0]         iter;
  logic signed [Q_W-1:0]   avg;

  logic                     wr_en;
  logic signed [OFF_W-1:0]  roff_calc;
  logic signed [OFF_W-1:0]  loff_calc;
  logic [SUM_W-1:0]         mag;
  logic [COUNT_W+1:0]       tdiff;
  logic                     qbit;
  logic [COUNT_W-1:0]       rem_next;
  logic signed [EXT_W-1:0]  diff;
  logic [EXT_W-1:0]         adiff;
  logic                     tol_fail;
  logic signed [EXT_W-1:0]  nb;
  logic signed [BASE_W-1:0] nb_sat;
  logic [CMP_W-1:0]         win_ext;
  logic [CMP_W-1:0]         win_c;
  logic                     over;

  assign pready       = 1'b1;
  assign wr_en        = psel && penable && pwrite;
  assign sample.ready = (state == IDLE);

  always_comb begin
    prdata = '0;
    case (paddr[wsbt_pkg::ADDR_W-1:2])
      wsbt_pkg::REG_ENABLE:    prdata = wsbt_pkg::DATA_W'(dyn_en);
      wsbt_pkg::REG_TOLERANCE: prdata = wsbt_pkg::DATA_W'(tolerance);
      wsbt_pkg::REG_WINDOW:    prdata = wsbt_pkg::DATA_W'(window);
      default:                 prdata = '0;
    endcase
  end

  always_comb begin
    roff_calc = $signed({2'b00, sample.right_raw})
              - $signed({baseline[0][BASE_W-1], baseline[0]});
    loff_calc = $signed({2'b00, sample.left_raw})
              - $signed({baseline[1][BASE_W-1], baseline[1]});

    mag = wsum[SUM_W-1] ? (~wsum + 1'b1) : wsum;

    // one restoring step: shift in the next dividend bit, try the count
    tdiff    = {1'b0, rem, dvd[Q_W-1]} - {2'b00, wcnt};
    qbit     = !tdiff[COUNT_W+1];
    rem_next = qbit ? tdiff[COUNT_W-1:0] : {rem[COUNT_W-2:0], dvd[Q_W-1]};

    diff     = $signed({avg[Q_W-1], avg}) - $signed({off[ch][OFF_W-1], off[ch]});
    adiff    = diff[EXT_W-1] ? (~diff + 1'b1) : diff;
    tol_fail = adiff > EXT_W'(tolerance);

    nb = $signed({{(EXT_W-BASE_W){baseline[ch][BASE_W-1]}}, baseline[ch]})
       + $signed({avg[Q_W-1], avg});
    if (nb > BASE_MAX) begin
      nb_sat = BASE_MAX[BASE_W-1:0];
    end else if (nb < BASE_MIN) begin
      nb_sat = BASE_MIN[BASE_W-1:0];
    end else begin
      nb_sat = nb[BASE_W-1:0];
    end

    win_ext = CMP_W'(window);
    win_c   = (win_ext > CMP_W'(MAX_WINDOW)) ? CMP_W'(MAX_WINDOW) : win_ext;
    over    = CMP_W'(wcnt) > win_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      ch           <= 1'b0;
      dyn_en       <= 1'b0;
      tolerance    <= wsbt_pkg::TOL_RESET;
      window       <= wsbt_pkg::WIN_RESET;
      sum[0]       <= '0;
      sum[1]       <= '0;
      count[0]     <= '0;
      count[1]     <= '0;
      baseline[0]  <= '0;
      baseline[1]  <= '0;
      result.valid <= 1'b0;
    end else begin
      if (wr_en) begin
        case (paddr[wsbt_pkg::ADDR_W-1:2])
          wsbt_pkg::REG_ENABLE:    dyn_en    <= pwdata[0];
          wsbt_pkg::REG_TOLERANCE: tolerance <= pwdata[wsbt_pkg::TOL_W-1:0];
          wsbt_pkg::REG_WINDOW:    window    <= pwdata[wsbt_pkg::WIN_W-1:0];
          default: ;
        endcase
      end

      // done reloads the result register itself
      if (result.valid && result.ready && state != DONE) begin
        result.valid <= 1'b0;
      end

      case (state)
        IDLE: begin
          if (sample.valid) begin
            off[0] <= roff_calc;
            off[1] <= loff_calc;
            reb[0] <= 1'b0;
            reb[1] <= 1'b0;
            ch     <= 1'b0;
            state  <= dyn_en ? SETUP : DONE;
          end
        end
        SETUP: begin
          wsum  <= sum[ch] + $signed({{(SUM_W-OFF_W){off[ch][OFF_W-1]}}, off[ch]});
          wcnt  <= count[ch] + 1'b1;
          state <= LOAD;
        end
        LOAD: begin
          // quotient is known to fit Q_W bits, so the top part starts as remainder
          neg   <= wsum[SUM_W-1];
          rem   <= mag[SUM_W-1:Q_W];
          dvd   <= mag[Q_W-1:0];
          iter  <= '0;
          state <= ITER;
        end
        ITER: begin
          rem  <= rem_next;
          dvd  <= {dvd[Q_W-2:0], qbit};
          iter <= iter + 1'b1;
          if (iter == IT_W'(Q_W - 1)) begin
            state <= AVG;
          end
        end
        AVG: begin
          avg   <= neg ? $signed(~dvd + 1'b1) : $signed(dvd);
          state <= DECIDE;
        end
        DECIDE: begin
          if (tol_fail) begin
            sum[ch]   <= '0;
            count[ch] <= '0;
          end else if (over) begin
            baseline[ch] <= nb_sat;
            sum[ch]      <= '0;
            count[ch]    <= '0;
            reb[ch]      <= 1'b1;
          end else begin
            sum[ch]   <= wsum;
            count[ch] <= wcnt;
          end
          if (!ch) begin
            ch    <= 1'b1;
            state <= SETUP;
          end else begin
            state <= DONE;
          end
        end
        DONE: begin
          if (!result.valid || result.ready) begin
            result.valid         <= 1'b1;
            result.right_base    <= baseline[0];
            result.left_base     <= baseline[1];
            result.right_offset  <= off[0];
            result.left_offset   <= off[1];
            result.right_rebased <= reb[0];
            result.left_rebased  <= reb[1];
            state                <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== sim/wall_sensor_baseline_tracker_top_test.sv =====
`timescale 1ns / 1ps

module wall_sensor_baseline_tracker_top_test;
  import wsbt_pkg::*;

  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int BASE_MAX = (1 << ADC_BITS) - 1;
  localparam int BASE_MIN = -(1 << ADC_BITS);
  localparam int RAW_MAX = (1 << ADC_BITS) - 1;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 50;

  typedef struct packed {
    logic [ADC_BITS-1:0] right_raw;
    logic [ADC_BITS-1:0] left_raw;
  } raw_pair_t;

  typedef struct {
    logic signed [ADC_BITS:0]   right_base;
    logic signed [ADC_BITS:0]   left_base;
    logic signed [ADC_BITS+1:0] right_offset;
    logic signed [ADC_BITS+1:0] left_offset;
    logic                       right_rebased;
    logic                       left_rebased;
  } tick_result_t;

  typedef struct {
    int sum;
    int count;
    int base;
  } chan_track_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  wsbt_sample_if sample_if ();
  wsbt_result_if result_if ();

  wall_sensor_baseline_tracker_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_if),
    .result  (result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // register shadow
  logic              cfg_enable;
  logic [TOL_W-1:0]  cfg_tolerance;
  logic [WIN_W-1:0]  cfg_window;
  chan_track_t       right_trk;
  chan_track_t       left_trk;

  raw_pair_t    pending_ticks[$];
  tick_result_t expected_ticks[$];
  int in_flight;
  int send_idle_pct;
  int recv_idle_pct;
  bit sample_taken;
  int quiet_cycles;
  int failures;
  int ticks_accepted;
  int results_checked;
  int right_rebases;
  int left_rebases;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic bit advance_channel(inout chan_track_t ch, input int offset);
    int win;
    int avg;
    int gap;
    win = (int'(cfg_window) > MAX_WINDOW) ? MAX_WINDOW : int'(cfg_window);
    ch.sum += offset;
    ch.count++;
    avg = ch.sum / ch.count;
    gap = avg - offset;
    if (gap < 0) gap = -gap;
    if (gap > int'(cfg_tolerance)) begin
      ch.sum = 0;
      ch.count = 0;
      return 1'b0;
    end
    if (ch.count > win) begin
      ch.base = ch.base + avg;
      if (ch.base > BASE_MAX) ch.base = BASE_MAX;
      if (ch.base < BASE_MIN) ch.base = BASE_MIN;
      ch.sum = 0;
      ch.count = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic tick_result_t track_tick(input raw_pair_t raw);
    tick_result_t res;
    int roff;
    int loff;
    roff = int'(raw.right_raw) - right_trk.base;
    loff = int'(raw.left_raw) - left_trk.base;
    res.right_rebased = 1'b0;
    res.left_rebased = 1'b0;
    if (cfg_enable) begin
      res.right_rebased = advance_channel(right_trk, roff);
      res.left_rebased = advance_channel(left_trk, loff);
    end
    res.right_base = right_trk.base[ADC_BITS:0];
    res.left_base = left_trk.base[ADC_BITS:0];
    res.right_offset = roff[ADC_BITS+1:0];
    res.left_offset = loff[ADC_BITS+1:0];
    return res;
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  // sender: a new item may go out once the current one was taken
  always @(negedge clk) begin : drive_samples
    raw_pair_t next;
    if (rst) begin
      sample_if.valid <= 1'b0;
    end else if (!sample_if.valid || sample_taken) begin
      if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next = pending_ticks.pop_front();
        sample_if.valid <= 1'b1;
        sample_if.right_raw <= next.right_raw;
        sample_if.left_raw <= next.left_raw;
      end else begin
        sample_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) result_if.ready <= 1'b0;
    else result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : watch_block
    tick_result_t want;
    bit result_taken;
    if (rst) begin
      sample_taken = 1'b0;
      quiet_cycles = 0;
    end else begin
      sample_taken = sample_if.valid && sample_if.ready;
      result_taken = result_if.valid && result_if.ready;
      if (sample_taken) begin
        want = track_tick({sample_if.right_raw, sample_if.left_raw});
        expected_ticks.push_back(want);
        ticks_accepted++;
        right_rebases += want.right_rebased;
        left_rebases += want.left_rebased;
      end
      if (result_taken) begin
        if (expected_ticks.size() == 0) begin
          $error("result item arrived with no tick outstanding");
          failures++;
        end else begin
          want = expected_ticks.pop_front();
          check_field("right_base", want.right_base, result_if.right_base);
          check_field("left_base", want.left_base, result_if.left_base);
          check_field("right_offset", want.right_offset, result_if.right_offset);
          check_field("left_offset", want.left_offset, result_if.left_offset);
          check_field("right_rebased", want.right_rebased, result_if.right_rebased);
          check_field("left_rebased", want.left_rebased, result_if.left_rebased);
          results_checked++;
          in_flight--;
        end
      end
      if (sample_taken || result_taken || (psel && penable)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout after %0d cycles without a handshake", quiet_cycles);
        $display("wall_sensor_baseline_tracker_top_test: FAIL");
        $finish;
      end
    end
  end

  task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] shadow_value(input logic [IDX_W-1:0] idx);
    case (idx)
      REG_ENABLE:    return DATA_W'(cfg_enable);
      REG_TOLERANCE: return DATA_W'(cfg_tolerance);
      REG_WINDOW:    return DATA_W'(cfg_window);
      default:       return '0;
    endcase
  endfunction

  task automatic read_reg(input logic [IDX_W-1:0] idx);
    logic [DATA_W-1:0] got;
    apb_access(1'b0, {idx, 2'b00}, '0, got);
    if (got !== shadow_value(idx)) begin
      $error("register %0d readback: expected %0d, got %0d", idx, shadow_value(idx), got);
      failures++;
    end
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] unused;
    apb_access(1'b1, {idx, 2'b00}, value, unused);
    case (idx)
      REG_ENABLE:    cfg_enable = value[0];
      REG_TOLERANCE: cfg_tolerance = value[TOL_W-1:0];
      REG_WINDOW:    cfg_window = value[WIN_W-1:0];
      default:       ;
    endcase
    if (idx != REG_UNUSED) read_reg(idx);
  endtask

  task automatic set_config(input logic en, input int tol, input int win);
    write_reg(REG_ENABLE, DATA_W'(en));
    write_reg(REG_TOLERANCE, DATA_W'(tol));
    write_reg(REG_WINDOW, DATA_W'(win));
  endtask

  task automatic queue_tick(input int right_raw, input int left_raw);
    raw_pair_t item;
    item.right_raw = right_raw[ADC_BITS-1:0];
    item.left_raw = left_raw[ADC_BITS-1:0];
    pending_ticks.push_back(item);
    in_flight++;
  endtask

  function automatic int pick_level();
    int roll;
    roll = $urandom_range(9);
    if (roll < 2) return 0;
    if (roll < 4) return RAW_MAX;
    return $urandom_range(RAW_MAX);
  endfunction

  function automatic int jitter(input int level, input int amp);
    int v;
    v = level + $urandom_range(2 * amp) - amp;
    if (v < 0) v = 0;
    if (v > RAW_MAX) v = RAW_MAX;
    return v;
  endfunction

  // mostly steady levels with small jitter so windows fill and rebase,
  // plus occasional level jumps and stray readings
  task automatic queue_drift_run(input int count);
    int right_level;
    int left_level;
    int amp;
    int jump_pct;
    right_level = pick_level();
    left_level = pick_level();
    amp = (cfg_tolerance < 16) ? cfg_tolerance / 2 : 8;
    jump_pct = (cfg_window > 15) ? 1 : 4;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < jump_pct) right_level = pick_level();
      if ($urandom_range(99) < jump_pct) left_level = pick_level();
      if ($urandom_range(99) < 5) begin
        queue_tick($urandom_range(RAW_MAX), $urandom_range(RAW_MAX));
      end else begin
        queue_tick(jitter(right_level, amp), jitter(left_level, amp));
      end
    end
  endtask

  function automatic int pick_tolerance();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return 0;
    if (roll == 1) return 255;
    if (roll < 5) return $urandom_range(255);
    return $urandom_range(3, 40);
  endfunction

  function automatic int pick_window();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return 0;
    if (roll == 1) return 31;
    if (roll == 2) return 30;
    if (roll < 5) return $urandom_range(31);
    return $urandom_range(1, 8);
  endfunction

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sample_if.valid = 1'b0;
    sample_if.right_raw = '0;
    sample_if.left_raw = '0;
    result_if.ready = 1'b0;
    cfg_enable = 1'b0;
    cfg_tolerance = TOL_RESET;
    cfg_window = WIN_RESET;
    right_trk = '{0, 0, 0};
    left_trk = '{0, 0, 0};
    in_flight = 0;
    failures = 0;
    ticks_accepted = 0;
    results_checked = 0;
    right_rebases = 0;
    left_rebases = 0;
    send_idle_pct = 29;
    recv_idle_pct = 75;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // registers come up at their defaults
    read_reg(REG_ENABLE);
    read_reg(REG_TOLERANCE);
    read_reg(REG_WINDOW);

    // disabled ticks: offsets against a zero baseline, no state change
    queue_tick(0, 0);
    queue_tick(RAW_MAX, RAW_MAX);
    queue_tick(RAW_MAX, 0);
    queue_tick(0, RAW_MAX);
    wait (in_flight == 0);

    // zero window: every tick rebases at once, both channels adding
    set_config(1'b1, 255, 0);
    queue_tick(RAW_MAX, 0);
    queue_tick(0, RAW_MAX);
    queue_tick(2048, 2048);
    wait (in_flight == 0);

    // zero tolerance: any change in offset clears the window
    set_config(1'b1, 0, 1);
    queue_tick(100, 100);
    queue_tick(100, 100);
    queue_tick(300, 101);
    queue_tick(300, 300);
    wait (in_flight == 0);

    // write to an unused index must leave all registers alone
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    read_reg(REG_ENABLE);
    read_reg(REG_TOLERANCE);
    read_reg(REG_WINDOW);

    // a pause in the middle of a window keeps the partial sums
    set_config(1'b1, 10, 5);
    queue_tick(500, 3000);
    queue_tick(501, 3001);
    wait (in_flight == 0);
    write_reg(REG_ENABLE, 32'd0);
    queue_tick(RAW_MAX, 0);
    queue_tick(0, RAW_MAX);
    wait (in_flight == 0);
    write_reg(REG_ENABLE, 32'd1);
    for (int i = 0; i < 4; i++) queue_tick(502, 2998);
    wait (in_flight == 0);

    for (int phase = 0; phase < 10; phase++) begin
      if (phase == 4) begin
        send_idle_pct = 75;
        recv_idle_pct = 29;
      end else if (phase == 7) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // window above the limit is clamped; then the widest exact window
      if (phase == 0) set_config(1'b1, 20, 31);
      else if (phase == 1) set_config(1'b1, 0, 30);
      else set_config($urandom_range(9) != 0, pick_tolerance(), pick_window());
      queue_drift_run(100);
      wait (in_flight == 0);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d ticks accepted, %0d result items checked, %0d right and %0d left rebases",
             ticks_accepted, results_checked, right_rebases, left_rebases);
    if (failures == 0) begin
      $display("wall_sensor_baseline_tracker_top_test: PASS");
    end else begin
      $display("%0d mismatches", failures);
      $display("wall_sensor_baseline_tracker_top_test: FAIL");
    end
    $finish;
  end

endmodule
